// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mts_pkg.sv =====
package mts_pkg;

    typedef logic signed [31:0] word_t;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;

    localparam word_t TOP_EMPTY = 32'shFFFF_FFFF;
    localparam word_t MIN_EMPTY = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_POP_RD
    } state_t;

endpackage

// ===== design/mts_ram.sv =====
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mts_ctrl.sv =====
`include "assert_macros.svh"

module mts_ctrl
    import mts_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [1:0]                 req_type,
    input  word_t                      push_value,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output word_t                      top_value,
    output word_t                      min_value,
    output logic [$clog2(DEPTH+1)-1:0] entry_count,
    output logic [1:0]                 status,
    output logic                       val_we,
    output logic [$clog2(DEPTH)-1:0]   val_waddr,
    output logic [$clog2(DEPTH)-1:0]   val_raddr,
    input  word_t                      val_rdata,
    output logic                       min_we,
    output logic [$clog2(DEPTH)-1:0]   min_waddr,
    output logic [$clog2(DEPTH)-1:0]   min_raddr,
    input  word_t                      min_rdata,
    output word_t                      wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE = CW'(1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   mptr_reg, mptr_next;
    word_t           cur_min_reg, cur_min_next;
    word_t           top_reg, top_next;
    logic            pend_hit_reg, pend_hit_next;
    logic            pend_mzero_reg, pend_mzero_next;
    logic            pend_empty_reg, pend_empty_next;
    logic            out_valid_reg, out_valid_next;
    word_t           out_top_reg, out_top_next;
    word_t           out_min_reg, out_min_next;
    logic [CW-1:0]   out_count_reg, out_count_next;
    status_t         out_status_reg, out_status_next;

    logic            accept;
    logic            is_push, is_pop, full, empty;
    logic            push_ok, pop_ok, le_min, hit;
    logic [CW-1:0]   ptr_dec, mptr_dec, val_rd, min_rd;

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign is_push = (req_type == REQ_PUSH);
    assign is_pop  = (req_type == REQ_POP);
    assign full    = (ptr_reg == FULL_COUNT);
    assign empty   = (ptr_reg == '0);
    assign push_ok = accept && is_push && !full;
    assign pop_ok  = accept && is_pop && !empty;
    assign le_min  = (push_value <= cur_min_reg);
    // popping the current minimum retires the top of the minimum stack
    assign hit     = (top_reg == cur_min_reg);

    assign ptr_dec  = ptr_reg - ONE;
    assign mptr_dec = (hit && (mptr_reg != '0)) ? (mptr_reg - ONE) : mptr_reg;
    assign val_rd   = ptr_dec - ONE;
    assign min_rd   = mptr_dec - ONE;

    assign wdata     = push_value;
    assign val_we    = push_ok;
    assign val_waddr = ptr_reg[AW-1:0];
    assign min_we    = push_ok && le_min && (mptr_reg < FULL_COUNT);
    assign min_waddr = mptr_reg[AW-1:0];
    assign val_raddr = val_rd[AW-1:0];
    assign min_raddr = min_rd[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_ok)
                begin
                    state_next = S_POP_RD;
                end
            end
            S_POP_RD:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ptr_next        = ptr_reg;
        mptr_next       = mptr_reg;
        cur_min_next    = cur_min_reg;
        top_next        = top_reg;
        pend_hit_next   = pend_hit_reg;
        pend_mzero_next = pend_mzero_reg;
        pend_empty_next = pend_empty_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_top_next    = out_top_reg;
        out_min_next    = out_min_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_ok)
                begin
                    ptr_next        = ptr_dec;
                    mptr_next       = mptr_dec;
                    pend_hit_next   = hit;
                    pend_mzero_next = (mptr_dec == '0);
                    pend_empty_next = (ptr_dec == '0);
                end
                else if (accept)
                begin
                    out_valid_next = 1'b1;
                    if (push_ok)
                    begin
                        ptr_next       = ptr_reg + ONE;
                        top_next       = push_value;
                        out_top_next   = push_value;
                        out_count_next = ptr_reg + ONE;
                        if (le_min)
                        begin
                            cur_min_next = push_value;
                            if (min_we)
                            begin
                                mptr_next = mptr_reg + ONE;
                            end
                        end
                        out_min_next    = le_min ? push_value : cur_min_reg;
                        out_status_next = ST_DONE;
                    end
                    else
                    begin
                        out_top_next   = empty ? TOP_EMPTY : top_reg;
                        out_min_next   = cur_min_reg;
                        out_count_next = ptr_reg;
                        if (is_push)
                        begin
                            out_status_next = ST_FULL;
                        end
                        else if (is_pop)
                        begin
                            out_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            out_status_next = ST_DONE;
                        end
                    end
                end
            end
            S_POP_RD:
            begin
                // store data for the new top entries has arrived
                top_next = pend_empty_reg ? TOP_EMPTY : val_rdata;
                if (pend_hit_reg)
                begin
                    cur_min_next = pend_mzero_reg ? MIN_EMPTY : min_rdata;
                end
                out_valid_next  = 1'b1;
                out_top_next    = pend_empty_reg ? TOP_EMPTY : val_rdata;
                out_min_next    = pend_hit_reg ? (pend_mzero_reg ? MIN_EMPTY : min_rdata)
                                               : cur_min_reg;
                out_count_next  = ptr_reg;
                out_status_next = ST_DONE;
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            mptr_reg      <= '0;
            cur_min_reg   <= MIN_EMPTY;
            top_reg       <= TOP_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            mptr_reg      <= mptr_next;
            cur_min_reg   <= cur_min_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_hit_reg   <= pend_hit_next;
        pend_mzero_reg <= pend_mzero_next;
        pend_empty_reg <= pend_empty_next;
        out_top_reg    <= out_top_next;
        out_min_reg    <= out_min_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid    = out_valid_reg;
    assign top_value   = out_top_reg;
    assign min_value   = out_min_reg;
    assign entry_count = out_count_reg;
    assign status      = out_status_reg;

    `ASSERT_ALWAYS(a_min_count_le_count, mptr_reg <= ptr_reg, "min stack deeper than stack")
    `ASSERT_ALWAYS(a_count_in_range, ptr_reg <= FULL_COUNT, "entry count beyond depth")
    `ASSERT_ALWAYS(a_slot_free_on_pop, (state_reg != S_POP_RD) || !out_valid_reg, "pop data with output slot busy")
    `ASSERT_NEXT(a_item_answered, accept, out_valid_reg || (state_reg == S_POP_RD), "accepted item left unanswered")

endmodule

// ===== design/min_tracking_stack.sv =====
// Replies: push, peek and refused requests answer in the cycle after acceptance;
// a pop answers after the registered store read and then the output register.
// Throughput: one item per cycle, but a pop blocks input during its store read.
// A result waiting on m_tready holds the input side off until it is taken.
// Reset (rst_n, asynchronous, active low) empties the stack; store contents
// are left as they are and are never read before being written again.
module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [31:0]              s_tdata,  // push_value
    input  logic [1:0]               s_tuser,  // req_type
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // top_value, min_value, entry_count, status, zero padding
    output logic [((66 + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = ((66 + CW + 7) / 8) * 8;

    word_t           top_value, min_value, wdata, val_rdata, min_rdata;
    logic [CW-1:0]   entry_count;
    logic [1:0]      status;
    logic            val_we, min_we;
    logic [AW-1:0]   val_waddr, val_raddr, min_waddr, min_raddr;

    mts_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req_type    (s_tuser),
        .push_value  (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .top_value   (top_value),
        .min_value   (min_value),
        .entry_count (entry_count),
        .status      (status),
        .val_we      (val_we),
        .val_waddr   (val_waddr),
        .val_raddr   (val_raddr),
        .val_rdata   (val_rdata),
        .min_we      (min_we),
        .min_waddr   (min_waddr),
        .min_raddr   (min_raddr),
        .min_rdata   (min_rdata),
        .wdata       (wdata)
    );

    mts_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    mts_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_min_ram (
        .clk   (clk),
        .we    (min_we),
        .waddr (min_waddr),
        .wdata (wdata),
        .raddr (min_raddr),
        .rdata (min_rdata)
    );

    assign m_tdata = OUT_W'({status, entry_count, min_value, top_value});

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import mts_pkg::*;

    localparam int DEPTH = 1024;
    localparam int OUT_W = ((66 + $clog2(DEPTH + 1) + 7) / 8) * 8;
    localparam logic [1:0] REQ_PEEK = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        word_t        top;
        word_t        minimum;
        logic [10:0]  count;
        logic [1:0]   status;
    } stack_reply_t;

    // Mirror of the stack and its minimum stack; one expected reply per request
    class min_stack_tracker;
        word_t        value_mem[DEPTH];
        word_t        min_mem[DEPTH];
        int unsigned  value_cnt;
        int unsigned  min_cnt;
        word_t        cur_min;
        stack_reply_t pending_replies[$];
        int           errors;
        int           full_drops;

        function new();
            value_cnt  = 0;
            min_cnt    = 0;
            cur_min    = MIN_EMPTY;
            errors     = 0;
            full_drops = 0;
        endfunction

        function void note_request(logic [1:0] req, word_t val);
            stack_reply_t r;
            r.status = ST_DONE;
            if (req == REQ_PUSH) begin
                if (value_cnt >= DEPTH) begin
                    r.status = ST_FULL;
                    full_drops++;
                end else begin
                    value_mem[value_cnt] = val;
                    value_cnt++;
                    if (val <= cur_min) begin
                        cur_min = val;
                        if (min_cnt < DEPTH) begin
                            min_mem[min_cnt] = val;
                            min_cnt++;
                        end
                    end
                end
            end else if (req == REQ_POP) begin
                if (value_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    value_cnt--;
                    if (value_mem[value_cnt] == cur_min) begin
                        if (min_cnt > 0)
                            min_cnt--;
                        cur_min = (min_cnt == 0) ? MIN_EMPTY : min_mem[min_cnt - 1];
                    end
                end
            end
            r.top     = (value_cnt == 0) ? TOP_EMPTY : value_mem[value_cnt - 1];
            r.minimum = cur_min;
            r.count   = value_cnt[10:0];
            pending_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [63:0] exp_v,
                                    logic signed [63:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_response(logic [OUT_W-1:0] data);
            stack_reply_t r;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected reply, expected none, got %h", $time, data);
                return;
            end
            r = pending_replies.pop_front();
            compare_field("top_value", r.top, $signed(data[31:0]));
            compare_field("min_value", r.minimum, $signed(data[63:32]));
            compare_field("entry_count", {53'd0, r.count}, {53'd0, data[74:64]});
            compare_field("status", {62'd0, r.status}, {62'd0, data[76:75]});
        endfunction

        function int unsigned outstanding();
            return pending_replies.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata = '0;   // push_value
    logic [1:0]        s_tuser = '0;   // req_type
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // top_value, min_value, entry_count, status, zero padding
    logic [OUT_W-1:0]  m_tdata;

    min_stack_tracker  tracker = new();
    int unsigned       cycle_count = 0;
    int                rx_stall = 0;
    bit                rx_calm = 1'b0;
    bit                tx_calm = 1'b0;

    min_tracking_stack #(.DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Reply side: check on acceptance, then draw the next stall
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            tracker.check_response(m_tdata);
            if ($urandom_range(0, 63) == 0)
                rx_calm = !rx_calm;
            rx_stall = rx_calm ? 0 : $urandom_range(0, 6);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall--;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_request(input logic [1:0] req, input word_t val);
        int gap;
        if ($urandom_range(0, 99) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= req;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_request(req, val);
    endtask

    // Hold the sender off until every reply is in
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic word_t pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $signed($urandom_range(0, 16)) - 8;
            7:          return 32'sh8000_0000;
            8:          return 32'sh7FFF_FFFF;
            default:    return ($urandom_range(0, 1) != 0) ? -32'sd1 : 32'sd0;
        endcase
    endfunction

    function automatic logic [1:0] pick_request(int push_pct, int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return REQ_PUSH;
        if (r < push_pct + pop_pct)
            return REQ_POP;
        return ($urandom_range(0, 3) == 0) ? REQ_SPARE : REQ_PEEK;
    endfunction

    initial
    begin
        int n;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // empty-stack cases, equal minima, extremes, then unwind
        send_request(REQ_PEEK, 32'sd0);
        send_request(REQ_SPARE, -32'sd1);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_PUSH, 32'sd5);
        send_request(REQ_PUSH, 32'sd5);
        send_request(REQ_PUSH, 32'sd7);
        send_request(REQ_PUSH, 32'sh7FFF_FFFF);
        send_request(REQ_PUSH, 32'sh8000_0000);
        send_request(REQ_PUSH, 32'sh8000_0000);
        send_request(REQ_PUSH, -32'sd1);
        send_request(REQ_PUSH, 32'sd0);
        send_request(REQ_PEEK, 32'sh5555_AAAA);
        repeat (9) send_request(REQ_POP, $urandom);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_PUSH, 32'sh7FFF_FFFF);
        send_request(REQ_SPARE, 32'sd3);
        send_request(REQ_POP, 32'sd0);
        wait_drained();

        // balanced mix
        for (n = 0; n < 300; n++)
            send_request(pick_request(55, 35), pick_value());
        wait_drained();

        // fill to full and keep pushing into it for a while
        n = 0;
        while (tracker.full_drops < 12 && n < 1500)
        begin
            send_request(pick_request(92, 4), pick_value());
            n++;
        end
        wait_drained();

        // drain-heavy, then a mix again
        for (n = 0; n < 250; n++)
            send_request(pick_request(20, 70), pick_value());
        for (n = 0; n < 100; n++)
            send_request(pick_request(45, 45), pick_value());

        wait_drained();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/mts_pkg.sv
design/mts_ram.sv
design/mts_ctrl.sv
design/min_tracking_stack.sv
tb/tb.sv
